// ----- rtl/lcmq_pkg.sv -----
`timescale 1ns / 1ps
// Shared sizes, widths, status codes and ring helpers for the linked-chunk message queue.
// Used by every module of the block; depends on nothing.
package lcmq_pkg;

   localparam int QUEUE_SLOTS = 16;
   localparam int POOL_CHUNKS = 64;
   localparam int CHUNK_SIZE  = 16;
   localparam int MAX_MESSAGE = 4096;

   localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
   localparam int CHUNK_W = (POOL_CHUNKS > 1) ? $clog2(POOL_CHUNKS) : 1;
   localparam int LINK_W  = $clog2(POOL_CHUNKS + 1);
   localparam int OFF_W   = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;
   localparam int LEN_W   = $clog2(MAX_MESSAGE + 1);
   localparam int FREE_W  = $clog2(POOL_CHUNKS + 1);
   localparam int GROUP   = 8;
   localparam int NUM_GROUPS = (POOL_CHUNKS + GROUP - 1) / GROUP;
   localparam int GROUP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int RSP_W   = 8 + LEN_W + SLOT_W + FREE_W;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_CHUNKS);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_POOL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
      ring_next = (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] queue_len(input logic [SLOT_W-1:0] w,
                                                  input logic [SLOT_W-1:0] r);
      logic [SLOT_W:0] t;
      if (w >= r) begin
         t = {1'b0, w} - {1'b0, r};
      end else begin
         t = {1'b0, w} + (SLOT_W + 1)'(QUEUE_SLOTS) - {1'b0, r};
      end
      queue_len = t[SLOT_W-1:0];
   endfunction

endpackage

// ----- rtl/lcmq_lowest_free.sv -----
`timescale 1ns / 1ps
// Lowest free chunk finder: a registered group summary followed by a pick inside the group.
// Depends on lcmq_pkg. The result is valid the cycle after the free vector settles.
module lcmq_lowest_free (
   input  logic                                 clock,
   input  logic [lcmq_pkg::POOL_CHUNKS-1:0]     free_vec,
   output logic [lcmq_pkg::CHUNK_W-1:0]         lowest
);

   localparam int PAD = lcmq_pkg::NUM_GROUPS * lcmq_pkg::GROUP;

   logic [PAD-1:0]                      padded;
   logic [lcmq_pkg::NUM_GROUPS-1:0]     grp_ff;
   logic [lcmq_pkg::GROUP_W-1:0]        sel;
   logic [lcmq_pkg::GROUP-1:0]          bits;
   logic [2:0]                          pos;

   assign padded = PAD'(free_vec);

   always_ff @(posedge clock) begin
      for (int g = 0; g < lcmq_pkg::NUM_GROUPS; g++) begin
         grp_ff[g] <= |padded[g*lcmq_pkg::GROUP +: lcmq_pkg::GROUP];
      end
   end

   always_comb begin
      sel = '0;
      for (int g = lcmq_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_ff[g]) begin
            sel = lcmq_pkg::GROUP_W'(g);
         end
      end
      bits = padded[sel*lcmq_pkg::GROUP +: lcmq_pkg::GROUP];
      pos = '0;
      for (int i = lcmq_pkg::GROUP - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = 3'(i);
         end
      end
      lowest = lcmq_pkg::CHUNK_W'({sel, pos});
   end

endmodule

// ----- rtl/linked_chunk_message_queue.sv -----
`timescale 1ns / 1ps
// Two-direction message queue whose messages live in linked fixed-size chunks.
// Depends on lcmq_pkg and lcmq_lowest_free.
//
// One item is handled at a time. A push byte passes the push and response states, and
// an allocate state between them when it opens a new chunk (the lowest-free-chunk pick).
// A byte that exhausts the pool or the length limit walks the chain under construction,
// with a link read state and a release state per chunk freed, since each link must be
// read from the link memory before the chunk is released. A pop byte passes the slot
// memory read, then the chunk data and link memory read. The result sits in an output
// register, and a new item is taken once the previous result has been loaded there.
module linked_chunk_message_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // data_in
   input  logic                      req_tlast,
   input  logic [1:0]                req_tuser,  // op, direction
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [lcmq_pkg::RSP_W-1:0] rsp_tdata, // data_out, msg_length, queue_length, free_chunks
   output logic                      rsp_tlast,
   output logic [1:0]                rsp_tuser   // status
);

   localparam int CW = lcmq_pkg::CHUNK_W;
   localparam int LW = lcmq_pkg::LINK_W;
   localparam int SW = lcmq_pkg::SLOT_W;
   localparam int OW = lcmq_pkg::OFF_W;
   localparam int NW = lcmq_pkg::LEN_W;
   localparam int FW = lcmq_pkg::FREE_W;
   localparam int PC = lcmq_pkg::POOL_CHUNKS;

   typedef enum logic [3:0] {
      S_IDLE, S_PUSH, S_ALLOC, S_FREE_RD, S_FREE_WR, S_POP, S_POP2, S_POP3, S_RESP
   } state_type;

   state_type state_ff;

   logic          d_ff, last_ff;
   logic [7:0]    byte_ff;

   logic [SW-1:0] ws_ff [2];
   logic [SW-1:0] rs_ff [2];
   logic [LW-1:0] head_ff [2];
   logic [LW-1:0] tail_ff [2];
   logic [NW-1:0] bcount_ff [2];
   logic [OW-1:0] boff_ff [2];
   logic [1:0]    drop_ff [2];
   logic [LW-1:0] rchunk_ff [2];
   logic [NW-1:0] rcount_ff [2];
   logic [OW-1:0] roff_ff [2];
   logic [FW-1:0] free_ff [2];
   logic [PC-1:0] used_ff [2];
   logic [PC-1:0] nvalid_ff [2];

   logic [LW-1:0] fc_ff;
   logic [FW-1:0] guard_ff;
   logic          nxv_ff;
   logic [LW-1:0] pc_ff;
   logic [NW-1:0] mlen_ff;

   logic [1:0]    res_status_ff;
   logic [7:0]    res_data_ff;
   logic          res_last_ff;
   logic [NW-1:0] res_mlen_ff;

   logic          rsp_valid_ff;
   logic [lcmq_pkg::RSP_W-1:0] rsp_data_ff;
   logic          rsp_last_ff;
   logic [1:0]    rsp_user_ff;

   logic [7:0]    bmem [2**(1+CW+OW)];
   logic [LW-1:0] nmem [2**(1+CW)];
   logic [CW+NW-1:0] smem [2**(1+SW)];
   logic [7:0]    br_q;
   logic [LW-1:0] nr_q;
   logic [CW+NW-1:0] sr_q;

   logic            bw_en, nw_en, sw_en;
   logic [CW+OW:0]  bw_addr, br_addr;
   logic [CW:0]     nw_addr, nr_addr;
   logic [LW-1:0]   nw_data;
   logic [SW:0]     sw_addr, sr_addr;
   logic [CW+NW-1:0] sw_data;

   logic [CW-1:0]   alloc_c;
   logic [LW-1:0]   alloc_link;
   logic [SW-1:0]   ws_next, rs_next;
   logic            push_full, push_long, push_new;
   logic [LW-1:0]   pop_c;
   logic [NW-1:0]   bcount_in, rcount_in;
   logic [OW-1:0]   boff_in, roff_in;
   logic            chunk_end, msg_end;
   logic [LW-1:0]   pop_nx, free_nx;

   lcmq_lowest_free u_lowest (
      .clock    (clock),
      .free_vec (~used_ff[d_ff]),
      .lowest   (alloc_c)
   );

   assign alloc_link = LW'(alloc_c);
   assign ws_next    = lcmq_pkg::ring_next(ws_ff[d_ff]);
   assign rs_next    = lcmq_pkg::ring_next(rs_ff[d_ff]);
   assign push_full  = (bcount_ff[d_ff] == '0) && (ws_next == rs_ff[d_ff]);
   assign push_long  = bcount_ff[d_ff] >= NW'(lcmq_pkg::MAX_MESSAGE);
   assign push_new   = boff_ff[d_ff] == '0;
   assign bcount_in  = bcount_ff[d_ff] + 1'b1;
   assign boff_in    = (boff_ff[d_ff] == OW'(lcmq_pkg::CHUNK_SIZE - 1)) ? '0 :
                       boff_ff[d_ff] + 1'b1;
   assign pop_c      = (rcount_ff[d_ff] == '0) ? LW'(sr_q[CW+NW-1:NW]) : rchunk_ff[d_ff];
   assign rcount_in  = rcount_ff[d_ff] + 1'b1;
   assign chunk_end  = roff_ff[d_ff] == OW'(lcmq_pkg::CHUNK_SIZE - 1);
   assign roff_in    = chunk_end ? '0 : roff_ff[d_ff] + 1'b1;
   assign msg_end    = rcount_in >= mlen_ff;
   assign pop_nx     = nxv_ff ? nr_q : lcmq_pkg::NULL_LINK;
   assign free_nx    = nxv_ff ? nr_q : lcmq_pkg::NULL_LINK;

   always_comb begin
      bw_en   = 1'b0;
      bw_addr = {d_ff, tail_ff[d_ff][CW-1:0], boff_ff[d_ff]};
      nw_en   = 1'b0;
      nw_addr = {d_ff, tail_ff[d_ff][CW-1:0]};
      nw_data = alloc_link;
      sw_en   = 1'b0;
      sw_addr = {d_ff, ws_next};
      sw_data = {head_ff[d_ff][CW-1:0], bcount_in};
      br_addr = {d_ff, pop_c[CW-1:0], roff_ff[d_ff]};
      nr_addr = {d_ff, pop_c[CW-1:0]};
      sr_addr = {d_ff, rs_next};
      case (state_ff)
         S_PUSH: begin
            if (drop_ff[d_ff] == '0 && !push_full && !push_long && !push_new) begin
               bw_en = 1'b1;
               sw_en = last_ff;
            end
         end
         S_ALLOC: begin
            bw_en   = 1'b1;
            bw_addr = {d_ff, alloc_c, boff_ff[d_ff]};
            nw_en   = tail_ff[d_ff] != lcmq_pkg::NULL_LINK;
            sw_en   = last_ff;
            if (tail_ff[d_ff] == lcmq_pkg::NULL_LINK) begin
               sw_data = {alloc_c, bcount_in};
            end
         end
         S_FREE_RD: begin
            nr_addr = {d_ff, fc_ff[CW-1:0]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (bw_en) begin
         bmem[bw_addr] <= byte_ff;
      end
      if (nw_en) begin
         nmem[nw_addr] <= nw_data;
      end
      if (sw_en) begin
         smem[sw_addr] <= sw_data;
      end
      br_q <= bmem[br_addr];
      nr_q <= nmem[nr_addr];
      sr_q <= smem[sr_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < 2; d++) begin
            ws_ff[d]     <= SW'(lcmq_pkg::QUEUE_SLOTS - 1);
            rs_ff[d]     <= SW'(lcmq_pkg::QUEUE_SLOTS - 1);
            head_ff[d]   <= lcmq_pkg::NULL_LINK;
            tail_ff[d]   <= lcmq_pkg::NULL_LINK;
            bcount_ff[d] <= '0;
            boff_ff[d]   <= '0;
            drop_ff[d]   <= lcmq_pkg::ST_OK;
            rchunk_ff[d] <= lcmq_pkg::NULL_LINK;
            rcount_ff[d] <= '0;
            roff_ff[d]   <= '0;
            free_ff[d]   <= FW'(PC);
            used_ff[d]   <= '0;
            nvalid_ff[d] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  d_ff     <= req_tuser[1];
                  byte_ff  <= req_tdata;
                  last_ff  <= req_tlast;
                  state_ff <= req_tuser[0] ? S_POP : S_PUSH;
               end
            end
            S_PUSH: begin
               res_data_ff <= '0;
               res_last_ff <= 1'b0;
               res_mlen_ff <= '0;
               res_status_ff <= lcmq_pkg::ST_OK;
               state_ff <= S_RESP;
               if (drop_ff[d_ff] != lcmq_pkg::ST_OK) begin
                  res_status_ff <= drop_ff[d_ff];
                  if (last_ff) begin
                     drop_ff[d_ff] <= lcmq_pkg::ST_OK;
                  end
               end else if (push_full) begin
                  res_status_ff <= lcmq_pkg::ST_FULL;
                  if (!last_ff) begin
                     drop_ff[d_ff] <= lcmq_pkg::ST_FULL;
                  end
               end else if (push_long || (push_new && free_ff[d_ff] == '0)) begin
                  fc_ff    <= head_ff[d_ff];
                  guard_ff <= '0;
                  state_ff <= S_FREE_RD;
               end else if (push_new) begin
                  state_ff <= S_ALLOC;
               end else begin
                  bcount_ff[d_ff] <= bcount_in;
                  boff_ff[d_ff]   <= boff_in;
                  if (last_ff) begin
                     ws_ff[d_ff]     <= ws_next;
                     head_ff[d_ff]   <= lcmq_pkg::NULL_LINK;
                     tail_ff[d_ff]   <= lcmq_pkg::NULL_LINK;
                     bcount_ff[d_ff] <= '0;
                     boff_ff[d_ff]   <= '0;
                  end
               end
            end
            S_ALLOC: begin
               used_ff[d_ff][alloc_c]   <= 1'b1;
               nvalid_ff[d_ff][alloc_c] <= 1'b0;
               if (tail_ff[d_ff] != lcmq_pkg::NULL_LINK) begin
                  nvalid_ff[d_ff][tail_ff[d_ff][CW-1:0]] <= 1'b1;
               end else begin
                  head_ff[d_ff] <= alloc_link;
               end
               free_ff[d_ff]   <= free_ff[d_ff] - 1'b1;
               tail_ff[d_ff]   <= alloc_link;
               bcount_ff[d_ff] <= bcount_in;
               boff_ff[d_ff]   <= boff_in;
               if (last_ff) begin
                  ws_ff[d_ff]     <= ws_next;
                  head_ff[d_ff]   <= lcmq_pkg::NULL_LINK;
                  tail_ff[d_ff]   <= lcmq_pkg::NULL_LINK;
                  bcount_ff[d_ff] <= '0;
                  boff_ff[d_ff]   <= '0;
               end
               state_ff <= S_RESP;
            end
            S_FREE_RD: begin
               if (fc_ff < LW'(PC) && guard_ff < FW'(PC)) begin
                  nxv_ff   <= nvalid_ff[d_ff][fc_ff[CW-1:0]];
                  state_ff <= S_FREE_WR;
               end else begin
                  head_ff[d_ff]   <= lcmq_pkg::NULL_LINK;
                  tail_ff[d_ff]   <= lcmq_pkg::NULL_LINK;
                  bcount_ff[d_ff] <= '0;
                  boff_ff[d_ff]   <= '0;
                  drop_ff[d_ff]   <= last_ff ? lcmq_pkg::ST_OK : lcmq_pkg::ST_POOL;
                  res_status_ff   <= lcmq_pkg::ST_POOL;
                  state_ff        <= S_RESP;
               end
            end
            S_FREE_WR: begin
               if (used_ff[d_ff][fc_ff[CW-1:0]]) begin
                  used_ff[d_ff][fc_ff[CW-1:0]] <= 1'b0;
                  free_ff[d_ff] <= free_ff[d_ff] + 1'b1;
               end
               nvalid_ff[d_ff][fc_ff[CW-1:0]] <= 1'b0;
               fc_ff    <= free_nx;
               guard_ff <= guard_ff + 1'b1;
               state_ff <= S_FREE_RD;
            end
            S_POP: begin
               res_data_ff <= '0;
               res_last_ff <= 1'b0;
               res_mlen_ff <= '0;
               if (rs_ff[d_ff] == ws_ff[d_ff]) begin
                  res_status_ff <= lcmq_pkg::ST_EMPTY;
                  state_ff      <= S_RESP;
               end else begin
                  res_status_ff <= lcmq_pkg::ST_OK;
                  state_ff      <= S_POP2;
               end
            end
            S_POP2: begin
               pc_ff   <= pop_c;
               mlen_ff <= sr_q[NW-1:0];
               nxv_ff  <= (pop_c < LW'(PC)) ? nvalid_ff[d_ff][pop_c[CW-1:0]] : 1'b0;
               rchunk_ff[d_ff] <= pop_c;
               state_ff <= S_POP3;
            end
            S_POP3: begin
               res_mlen_ff <= mlen_ff;
               res_data_ff <= (pc_ff < LW'(PC)) ? br_q : 8'd0;
               rcount_ff[d_ff] <= rcount_in;
               roff_ff[d_ff]   <= roff_in;
               if ((chunk_end || msg_end) && pc_ff < LW'(PC)) begin
                  rchunk_ff[d_ff] <= pop_nx;
                  if (used_ff[d_ff][pc_ff[CW-1:0]]) begin
                     used_ff[d_ff][pc_ff[CW-1:0]] <= 1'b0;
                     free_ff[d_ff] <= free_ff[d_ff] + 1'b1;
                  end
                  nvalid_ff[d_ff][pc_ff[CW-1:0]] <= 1'b0;
               end
               if (msg_end) begin
                  res_last_ff     <= 1'b1;
                  rs_ff[d_ff]     <= rs_next;
                  rcount_ff[d_ff] <= '0;
                  roff_ff[d_ff]   <= '0;
                  rchunk_ff[d_ff] <= lcmq_pkg::NULL_LINK;
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= res_status_ff;
                  rsp_last_ff  <= res_last_ff;
                  rsp_data_ff  <= {free_ff[d_ff],
                                   lcmq_pkg::queue_len(ws_ff[d_ff], rs_ff[d_ff]),
                                   res_mlen_ff, res_data_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- verif/linked_chunk_message_queue_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for linked_chunk_message_queue: push and pop items on both
// directions, predicted by a queue-and-pool model kept in a small scoreboard class.
// Depends on lcmq_pkg and the RTL of the block.
module linked_chunk_message_queue_tb;
   import lcmq_pkg::*;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        data;
      logic              last;
      logic [LEN_W-1:0]  mlen;
      logic [SLOT_W-1:0] qlen;
      logic [FREE_W-1:0] free;
   } rsp_type;

   class queue_scoreboard;
      logic [7:0] chunk_data[2][POOL_CHUNKS*CHUNK_SIZE];
      int         link[2][POOL_CHUNKS];
      bit         taken[2][POOL_CHUNKS];
      int         head_of_slot[2][QUEUE_SLOTS];
      int         len_of_slot[2][QUEUE_SLOTS];
      int         wr_slot[2], rd_slot[2];
      int         build_first[2], build_last[2], build_len[2], drop_code[2];
      int         rd_chunk[2], rd_pos[2], free_left[2];
      rsp_type    pending[$];
      int         errors;

      function new();
         errors = 0;
         for (int d = 0; d < 2; d++) begin
            for (int c = 0; c < POOL_CHUNKS; c++) begin
               link[d][c] = POOL_CHUNKS;
               taken[d][c] = 0;
            end
            for (int i = 0; i < POOL_CHUNKS * CHUNK_SIZE; i++) chunk_data[d][i] = 8'd0;
            for (int s = 0; s < QUEUE_SLOTS; s++) begin
               head_of_slot[d][s] = 0;
               len_of_slot[d][s] = 0;
            end
            wr_slot[d] = QUEUE_SLOTS - 1;
            rd_slot[d] = QUEUE_SLOTS - 1;
            build_first[d] = POOL_CHUNKS;
            build_last[d] = POOL_CHUNKS;
            build_len[d] = 0;
            drop_code[d] = 0;
            rd_chunk[d] = POOL_CHUNKS;
            rd_pos[d] = 0;
            free_left[d] = POOL_CHUNKS;
         end
      endfunction

      function int next_slot(int s);
         return (s + 1 >= QUEUE_SLOTS) ? 0 : s + 1;
      endfunction

      function void release_one(int d, int c);
         if (taken[d][c]) begin
            taken[d][c] = 0;
            free_left[d]++;
         end
         link[d][c] = POOL_CHUNKS;
      endfunction

      function void discard_build(int d);
         int c, nx, guard;
         c = build_first[d];
         guard = 0;
         while (c < POOL_CHUNKS && guard < POOL_CHUNKS) begin
            nx = link[d][c];
            release_one(d, c);
            c = nx;
            guard++;
         end
         build_first[d] = POOL_CHUNKS;
         build_last[d] = POOL_CHUNKS;
         build_len[d] = 0;
      endfunction

      function int append_byte(int d, logic [7:0] b, bit fin);
         int c, s;
         if (drop_code[d] != 0) begin
            c = drop_code[d];
            if (fin) drop_code[d] = 0;
            return c;
         end
         if (build_len[d] == 0 && next_slot(wr_slot[d]) == rd_slot[d]) begin
            if (!fin) drop_code[d] = int'(ST_FULL);
            return int'(ST_FULL);
         end
         if (build_len[d] >= MAX_MESSAGE) begin
            discard_build(d);
            if (!fin) drop_code[d] = int'(ST_POOL);
            return int'(ST_POOL);
         end
         if (build_len[d] % CHUNK_SIZE == 0) begin
            c = POOL_CHUNKS;
            for (int k = 0; k < POOL_CHUNKS; k++) begin
               if (!taken[d][k]) begin
                  c = k;
                  break;
               end
            end
            if (c == POOL_CHUNKS) begin
               discard_build(d);
               if (!fin) drop_code[d] = int'(ST_POOL);
               return int'(ST_POOL);
            end
            taken[d][c] = 1;
            link[d][c] = POOL_CHUNKS;
            free_left[d]--;
            if (build_last[d] < POOL_CHUNKS) link[d][build_last[d]] = c;
            else build_first[d] = c;
            build_last[d] = c;
         end
         chunk_data[d][build_last[d]*CHUNK_SIZE + build_len[d] % CHUNK_SIZE] = b;
         build_len[d]++;
         if (fin) begin
            s = next_slot(wr_slot[d]);
            head_of_slot[d][s] = build_first[d];
            len_of_slot[d][s] = build_len[d];
            wr_slot[d] = s;
            build_first[d] = POOL_CHUNKS;
            build_last[d] = POOL_CHUNKS;
            build_len[d] = 0;
         end
         return int'(ST_OK);
      endfunction

      function void note_item(bit op, bit d, logic [7:0] b, bit fin);
         rsp_type e;
         int      s, c;
         e = '0;
         if (!op) begin
            e.status = 2'(append_byte(d, b, fin));
         end else if (rd_slot[d] == wr_slot[d]) begin
            e.status = ST_EMPTY;
         end else begin
            s = next_slot(rd_slot[d]);
            e.status = ST_OK;
            e.mlen = LEN_W'(len_of_slot[d][s]);
            if (rd_pos[d] == 0) rd_chunk[d] = head_of_slot[d][s];
            c = rd_chunk[d];
            if (c < POOL_CHUNKS) e.data = chunk_data[d][c*CHUNK_SIZE + rd_pos[d] % CHUNK_SIZE];
            rd_pos[d]++;
            if ((rd_pos[d] % CHUNK_SIZE == 0 || rd_pos[d] >= len_of_slot[d][s])
                && c < POOL_CHUNKS) begin
               rd_chunk[d] = link[d][c];
               release_one(d, c);
            end
            if (rd_pos[d] >= len_of_slot[d][s]) begin
               e.last = 1'b1;
               rd_slot[d] = s;
               rd_pos[d] = 0;
               rd_chunk[d] = POOL_CHUNKS;
            end
         end
         e.qlen = SLOT_W'((wr_slot[d] - rd_slot[d] + QUEUE_SLOTS) % QUEUE_SLOTS);
         e.free = FREE_W'(free_left[d]);
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected: %p", $realtime, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, got.status);
            errors++;
         end
         if (got.data !== e.data) begin
            $display("%0t: data_out expected %0h actual %0h", $realtime, e.data, got.data);
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last_out expected %0d actual %0d", $realtime, e.last, got.last);
            errors++;
         end
         if (got.mlen !== e.mlen) begin
            $display("%0t: msg_length expected %0d actual %0d", $realtime, e.mlen, got.mlen);
            errors++;
         end
         if (got.qlen !== e.qlen) begin
            $display("%0t: queue_length expected %0d actual %0d", $realtime, e.qlen, got.qlen);
            errors++;
         end
         if (got.free !== e.free) begin
            $display("%0t: free_chunks expected %0d actual %0d", $realtime, e.free, got.free);
            errors++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 4000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = 8'd0;
   logic             req_tlast = 1'b0;
   logic [1:0]       req_tuser = 2'd0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic [1:0]       rsp_tuser;

   queue_scoreboard sb = new();
   bit              quiet = 0;
   int              results_seen = 0;
   int              left_in_msg[2];

   always #2 clock = ~clock;

   linked_chunk_message_queue u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   task automatic send_item(bit op, bit d, logic [7:0] b, bit fin);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {d, op};
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      sb.note_item(op, d, b, fin);
   endtask

   task automatic send_message_byte(bit d);
      if (left_in_msg[d] == 0) begin
         case ($urandom_range(0, 5))
            0: left_in_msg[d] = CHUNK_SIZE;
            1: left_in_msg[d] = 2 * CHUNK_SIZE;
            2: left_in_msg[d] = $urandom_range(CHUNK_SIZE + 1, 60);
            default: left_in_msg[d] = $urandom_range(1, 12);
         endcase
      end
      left_in_msg[d]--;
      send_item(1'b0, d, 8'($urandom), left_in_msg[d] == 0);
   endtask

   always @(posedge clock) begin
      int stall_left;
      bit held;
      if (rsp_tvalid && rsp_tready) begin
         sb.check_result({rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[8 +: LEN_W],
                          rsp_tdata[8+LEN_W +: SLOT_W], rsp_tdata[8+LEN_W+SLOT_W +: FREE_W]});
         results_seen++;
      end
      if (!held && results_seen >= 200) begin
         held = 1;
         stall_left = 400;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle = 0;
         else idle++;
      end
      $display("linked_chunk_message_queue_tb: done, errors");
      $finish;
   end

   initial begin
      int push_pct;
      left_in_msg[0] = 0;
      left_in_msg[1] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pops, extreme bytes, filling the ring and a dropped message.
      send_item(1'b1, 1'b0, 8'hff, 1'b1);
      send_item(1'b1, 1'b1, 8'h00, 1'b0);
      send_item(1'b0, 1'b1, 8'h00, 1'b0);
      send_item(1'b0, 1'b1, 8'hff, 1'b1);
      send_item(1'b1, 1'b1, 8'h00, 1'b0);
      send_item(1'b1, 1'b1, 8'h00, 1'b0);
      for (int i = 0; i < QUEUE_SLOTS - 1; i++) send_item(1'b0, 1'b0, 8'(i * 17), 1'b1);
      send_item(1'b0, 1'b0, 8'haa, 1'b0);
      send_item(1'b0, 1'b0, 8'h55, 1'b1);
      send_item(1'b1, 1'b0, 8'h00, 1'b0);

      // Pool exhaustion: one message longer than the whole pool, then its tail bytes.
      for (int i = 0; i < POOL_CHUNKS * CHUNK_SIZE + 3; i++)
         send_item(1'b0, 1'b1, 8'($urandom), i == POOL_CHUNKS * CHUNK_SIZE + 2);

      for (int i = 0; i < 300; i++) begin
         if (i % 75 == 0) begin
            case ($urandom_range(0, 3))
               0: push_pct = 30;
               1: push_pct = 50;
               2: push_pct = 70;
               default: push_pct = 90;
            endcase
         end
         if (i >= 250) quiet = 1;
         if ($urandom_range(1, 100) <= push_pct) send_message_byte(1'($urandom));
         else send_item(1'b1, 1'($urandom), 8'($urandom), 1'($urandom));
      end
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("linked_chunk_message_queue_tb: done, clean");
      end else begin
         $display("linked_chunk_message_queue_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lcmq_pkg.sv
rtl/lcmq_lowest_free.sv
rtl/linked_chunk_message_queue.sv
verif/linked_chunk_message_queue_tb.sv
